### design/tle_pkg.sv
package tle_pkg;

  // Line geometry
  localparam int LINE_CHARS = 40;
  localparam int COUNT_W = $clog2(LINE_CHARS + 1);
  localparam int ADDR_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam logic [COUNT_W-1:0] LINE_FULL = COUNT_W'(LINE_CHARS);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KILL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_ERASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END        = 2'd3;

  localparam logic [7:0] ERASE_RESET      = 8'h08;
  localparam logic [7:0] KILL_RESET       = 8'h15;
  localparam logic [7:0] WORD_ERASE_RESET = 8'h17;
  localparam logic [7:0] END_RESET        = 8'h04;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_K      = 8'h4B;

  typedef struct packed {
    logic [7:0] erase_char;
    logic [7:0] kill_char;
    logic [7:0] word_erase_char;
    logic [7:0] end_char;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_ERASE,
    OP_KILL,
    OP_WORD,
    OP_NEWLINE,
    OP_END,
    OP_BELL
  } key_op_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_WRAP,
    CMD_ERASE,
    CMD_KILL,
    CMD_WORD,
    CMD_DONE
  } cmd_kind_t;

  typedef enum logic {
    FR_IDLE,
    FR_SCAN
  } front_state_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic [3:0] tens;
    logic [3:0] ones;
  } cmd_t;

  // Decimal tens digit of a column count: count the thresholds reached
  function automatic logic [3:0] dec_tens(input logic [COUNT_W-1:0] n);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (int'(n) >= 10 * k) t = t + 4'd1;
    end
    return t;
  endfunction

  function automatic logic [3:0] dec_ones(input logic [COUNT_W-1:0] n,
                                          input logic [3:0] t);
    return 4'(int'(n) - 10 * int'(t));
  endfunction

  // Number of echo bytes a command produces
  function automatic logic [3:0] cmd_len(input cmd_t c);
    logic [3:0] len;
    case (c.kind)
      CMD_CHAR:  len = 4'd1;
      CMD_WRAP:  len = 4'd2;
      CMD_ERASE: len = 4'd6;
      CMD_KILL:  len = 4'd5;
      CMD_WORD:  len = (c.tens == 4'd0) ? 4'd7 : 4'd8;
      CMD_DONE:  len = 4'd1;
      default:   len = 4'd1;
    endcase
    return len;
  endfunction

  // Echo byte number 'step' of a command
  function automatic logic [7:0] cmd_byte(input cmd_t c, input logic [2:0] step);
    logic [3:0] k;
    logic [7:0] b;
    k = {1'b0, step};
    b = CH_NUL;
    case (c.kind)
      CMD_CHAR:  b = c.data;
      CMD_WRAP:  b = (step == 3'd0) ? CH_LF : c.data;
      CMD_ERASE: begin
        case (step)
          3'd0, 3'd3: b = CH_ESC;
          3'd1, 3'd4: b = CH_LBRACK;
          3'd2:       b = CH_D;
          default:    b = CH_K;
        endcase
      end
      CMD_KILL: begin
        case (step)
          3'd0:    b = CH_ESC;
          3'd1:    b = CH_LBRACK;
          3'd2:    b = CH_TWO;
          3'd3:    b = CH_K;
          default: b = CH_CR;
        endcase
      end
      CMD_WORD: begin
        // Skip the tens digit slot for counts below ten
        if (c.tens == 4'd0 && k >= 4'd2) k = k + 4'd1;
        case (k)
          4'd0, 4'd5: b = CH_ESC;
          4'd1, 4'd6: b = CH_LBRACK;
          4'd2:       b = CH_ZERO + {4'd0, c.tens};
          4'd3:       b = CH_ZERO + {4'd0, c.ones};
          4'd4:       b = CH_D;
          default:    b = CH_K;
        endcase
      end
      CMD_DONE: b = CH_NUL;
      default:  b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

### design/tle_ram.sv
module tle_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### design/tle_front.sv
module tle_front import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_regs_t  cfg,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       full,
  output logic       push,
  output cmd_t       push_cmd
);

  front_state_t state, state_next;
  logic [COUNT_W-1:0] line_count, line_count_next;
  logic               stopped, stopped_next;
  logic [COUNT_W-1:0] scan_idx, scan_idx_next;
  logic               chk_valid, chk_valid_next;
  logic [COUNT_W-1:0] chk_idx, chk_idx_next;
  logic               prev_space, prev_space_next;
  logic [COUNT_W-1:0] word_col, word_col_next;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  key_op_t key_op;
  logic    accept;
  logic    scan_done;

  tle_ram #(.WIDTH(1), .DEPTH(LINE_CHARS)) u_marks (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready  = (state == FR_IDLE) && !full;
  assign accept    = s_tvalid && s_tready;
  assign scan_done = chk_valid && (chk_idx == line_count - COUNT_W'(1));

  // Classify the key; printable wins over any register match
  always_comb begin
    if (s_tdata inside {[CH_SPACE:CH_TILDE]}) key_op = OP_PRINT;
    else if (s_tdata == cfg.erase_char)       key_op = OP_ERASE;
    else if (s_tdata == cfg.kill_char)        key_op = OP_KILL;
    else if (s_tdata == cfg.word_erase_char)  key_op = OP_WORD;
    else if (s_tdata inside {CH_LF, CH_CR})   key_op = OP_NEWLINE;
    else if (s_tdata == cfg.end_char)         key_op = OP_END;
    else                                      key_op = OP_BELL;
  end

  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (accept && !stopped && key_op == OP_WORD && line_count != '0) begin
          state_next = FR_SCAN;
        end
      end
      FR_SCAN: begin
        if (scan_done) state_next = FR_IDLE;
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    logic [COUNT_W-1:0] start_now;
    logic [COUNT_W-1:0] n;
    logic               issue;
    line_count_next = line_count;
    stopped_next    = stopped;
    scan_idx_next   = scan_idx;
    chk_valid_next  = 1'b0;
    chk_idx_next    = chk_idx;
    prev_space_next = prev_space;
    word_col_next   = word_col;
    push            = 1'b0;
    push_cmd        = '{kind: CMD_CHAR, data: s_tdata, tens: 4'd0, ones: 4'd0};
    ram_we          = 1'b0;
    ram_waddr       = (line_count == LINE_FULL) ? '0 : line_count[ADDR_W-1:0];
    ram_wdata       = (s_tdata == CH_SPACE);
    ram_raddr       = scan_idx[ADDR_W-1:0];
    start_now       = word_col;
    n               = '0;
    issue           = 1'b0;
    case (state)
      FR_IDLE: begin
        if (accept && !stopped) begin
          case (key_op)
            OP_PRINT: begin
              ram_we = 1'b1;
              push   = 1'b1;
              if (line_count == LINE_FULL) begin
                // Full line: newline first, char lands in column zero
                push_cmd.kind   = CMD_WRAP;
                line_count_next = COUNT_W'(1);
              end else begin
                line_count_next = line_count + COUNT_W'(1);
              end
            end
            OP_ERASE: begin
              if (line_count != '0) begin
                line_count_next = line_count - COUNT_W'(1);
                push            = 1'b1;
                push_cmd.kind   = CMD_ERASE;
              end
            end
            OP_KILL: begin
              line_count_next = '0;
              push            = 1'b1;
              push_cmd.kind   = CMD_KILL;
            end
            OP_WORD: begin
              scan_idx_next   = '0;
              prev_space_next = 1'b1;
              word_col_next   = '0;
            end
            OP_NEWLINE: begin
              line_count_next = '0;
              push            = 1'b1;
              push_cmd.data   = CH_LF;
            end
            OP_END: begin
              if (line_count == '0) begin
                stopped_next  = 1'b1;
                push          = 1'b1;
                push_cmd.kind = CMD_DONE;
                push_cmd.data = CH_NUL;
              end
            end
            OP_BELL: begin
              push          = 1'b1;
              push_cmd.data = CH_BEL;
            end
            default: ;
          endcase
        end
      end
      FR_SCAN: begin
        // Read one column a cycle; check it when its data returns
        issue          = (scan_idx < line_count);
        scan_idx_next  = issue ? scan_idx + COUNT_W'(1) : scan_idx;
        chk_valid_next = issue;
        chk_idx_next   = scan_idx;
        if (chk_valid) begin
          if (!ram_rdata && prev_space) start_now = chk_idx;
          word_col_next   = start_now;
          prev_space_next = ram_rdata;
        end
        if (scan_done) begin
          n               = line_count - start_now;
          line_count_next = start_now;
          push            = 1'b1;
          push_cmd.kind   = CMD_WORD;
          push_cmd.tens   = dec_tens(n);
          push_cmd.ones   = dec_ones(n, push_cmd.tens);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FR_IDLE;
      line_count <= '0;
      stopped    <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      stopped    <= stopped_next;
      chk_valid  <= chk_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx   <= scan_idx_next;
    chk_idx    <= chk_idx_next;
    prev_space <= prev_space_next;
    word_col   <= word_col_next;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_FULL)
    else $error("line count beyond line width");

  a_stop_sticks: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped)
    else $error("stopped flag cleared without reset");

endmodule

### design/tle_queue.sv
module tle_queue import tle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command popped from an empty queue");

endmodule

### design/tle_back.sv
module tle_back import tle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic       m_tuser
);

  logic [2:0] step, step_next;
  logic       m_tvalid_next;
  logic       load;
  logic       last;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign last = ({1'b0, step} == cmd_len(head_cmd) - 4'd1);
  assign pop  = load && last;

  always_comb begin
    step_next     = step;
    m_tvalid_next = m_tvalid && !m_tready;
    if (load) begin
      m_tvalid_next = 1'b1;
      step_next     = last ? 3'd0 : step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      step     <= step_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cmd_byte(head_cmd, step);
      m_tlast <= last;
      m_tuser <= (head_cmd.kind == CMD_DONE);
    end
  end

  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == CH_NUL))
    else $error("done result is not a single zero byte");

endmodule

### design/terminal_line_editor_top.sv
// Terminal line editor: one typed byte in, its echo bytes out.
// The key's command passes through the queue and the registered output stage before
//   its first echo byte appears; a word erase scans the line first.
// Throughput: one echo byte per cycle while m_tready is high, 0..8 per key; a word
//   erase holds s_tready low while it scans. Reset (rst, synchronous): line empty,
//   session running, queue and output emptied, registers to defaults; marks kept.
module terminal_line_editor_top import tle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // Key input
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] key_byte
  // Echo output
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [7:0] echo_byte
  output logic                 m_tlast,   // is_last
  output logic                 m_tuser    // [0] session_done
);

  cfg_regs_t cfg;
  logic      push;
  cmd_t      push_cmd;
  logic      full;
  logic      pop;
  logic      head_valid;
  cmd_t      head_cmd;

  // Control codes; the user must write them only while the editor is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.erase_char      <= ERASE_RESET;
      cfg.kill_char       <= KILL_RESET;
      cfg.word_erase_char <= WORD_ERASE_RESET;
      cfg.end_char        <= END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ERASE:      cfg.erase_char      <= cfg_data;
        REG_KILL:       cfg.kill_char       <= cfg_data;
        REG_WORD_ERASE: cfg.word_erase_char <= cfg_data;
        REG_END:        cfg.end_char        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: take keys, track the line, scan columns for word erase,
  // and hand one command per echo sequence to the queue
  tle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Short command queue lets the front keep taking keys while
  // the back is still spelling out an escape sequence
  tle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: expand each command into echo bytes, one per cycle while m_tready is high,
  // through a registered output stage
  tle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

### tb/tb.sv
module tb;
  import tle_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Idle cycles with no item moving on either side before the run is given up
  localparam int STALL_LIMIT = 2000;
  // Cycles to let a word scan or a no-echo key finish before the block counts as idle
  localparam int SETTLE_CYCLES = 60;
  // Length of the one long receiver hold-off
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [7:0] echo;
    logic       last;
    logic       done;
  } echo_item_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;

  terminal_line_editor_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [7:0] key_byte
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [7:0] echo_byte
    .m_tlast   (m_tlast),   // is_last
    .m_tuser   (m_tuser)    // [0] session_done
  );

  always #6 clk = ~clk;

  // Keys waiting to be offered, and echo bytes owed by the block, oldest first
  logic [7:0] pending_keys[$];
  echo_item_t echo_due[$];
  int         fail_count = 0;

  // Editor state as the block should hold it
  cfg_regs_t            keymap = '{ERASE_RESET, KILL_RESET, WORD_ERASE_RESET, END_RESET};
  logic [COUNT_W-1:0]   line_len = '0;
  bit                   col_space[LINE_CHARS];
  bit                   stopped = 1'b0;

  // Pacing knobs, changed per phase by the stimulus process
  int gap_max = 4;
  int burst_max = 8;
  int stall_max = 3;
  bit long_hold_ask = 1'b0;

  // Work out the echo bytes of one accepted key and advance the line state
  task automatic echo_for_key(input logic [7:0] key);
    logic [7:0]         seq[$];
    logic [COUNT_W-1:0] start;
    logic [COUNT_W-1:0] n;
    bit                 prev_sp;
    bit                 done;
    echo_item_t         item;
    done = 1'b0;
    if (stopped) return;
    if (key >= CH_SPACE && key <= CH_TILDE) begin
      // Full line: wrap before storing the character
      if (line_len >= LINE_FULL) begin
        seq.push_back(CH_LF);
        line_len = '0;
      end
      col_space[line_len] = (key == CH_SPACE);
      line_len++;
      seq.push_back(key);
    end else if (key == keymap.erase_char) begin
      if (line_len != 0) begin
        line_len--;
        seq.push_back(CH_ESC); seq.push_back(CH_LBRACK); seq.push_back(CH_D);
        seq.push_back(CH_ESC); seq.push_back(CH_LBRACK); seq.push_back(CH_K);
      end
    end else if (key == keymap.kill_char) begin
      line_len = '0;
      seq.push_back(CH_ESC); seq.push_back(CH_LBRACK); seq.push_back(CH_TWO);
      seq.push_back(CH_K); seq.push_back(CH_CR);
    end else if (key == keymap.word_erase_char) begin
      if (line_len != 0) begin
        // Last word starts at the last nonspace column after a space or the line start
        start = '0;
        prev_sp = 1'b1;
        for (int i = 0; i < int'(line_len); i++) begin
          if (!col_space[i] && prev_sp) start = COUNT_W'(i);
          prev_sp = col_space[i];
        end
        n = line_len - start;
        line_len = start;
        seq.push_back(CH_ESC); seq.push_back(CH_LBRACK);
        if (n >= 10) seq.push_back(CH_ZERO + 8'(n / 10));
        seq.push_back(CH_ZERO + 8'(n % 10));
        seq.push_back(CH_D);
        seq.push_back(CH_ESC); seq.push_back(CH_LBRACK); seq.push_back(CH_K);
      end
    end else if (key == CH_LF || key == CH_CR) begin
      line_len = '0;
      seq.push_back(CH_LF);
    end else if (key == keymap.end_char) begin
      if (line_len == 0) begin
        stopped = 1'b1;
        done = 1'b1;
        seq.push_back(CH_NUL);
      end
    end else begin
      seq.push_back(CH_BEL);
    end
    foreach (seq[i]) begin
      item.echo = seq[i];
      item.last = (i == seq.size() - 1);
      item.done = done;
      echo_due.push_back(item);
    end
  endtask

  // Sender: bursts of random length with random gaps; predict on every accepted key
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) echo_for_key(s_tdata);
      // Hold the offered key until it is taken
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0 || pending_keys.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_keys.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, burst_max);
            gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end
      end
    end
  end

  // Receiver: check each accepted echo item, then pick the next ready state
  int hold_left = 0;
  int rdy_left = 0;
  bit rdy_on = 1'b1;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (echo_due.size() == 0) begin
          if (fail_count < 50)
            $display("%0t ns: unexpected echo item: got byte %h last %b done %b",
                     $time, m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else if (m_tdata !== echo_due[0].echo || m_tlast !== echo_due[0].last ||
                     m_tuser !== echo_due[0].done) begin
          if (fail_count < 50)
            $display("%0t ns: echo mismatch: expected byte %h last %b done %b, got %h %b %b",
                     $time, echo_due[0].echo, echo_due[0].last, echo_due[0].done,
                     m_tdata, m_tlast, m_tuser);
          fail_count++;
          void'(echo_due.pop_front());
        end else begin
          void'(echo_due.pop_front());
        end
      end
      if (long_hold_ask) begin
        long_hold_ask = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        // Long hold-off: let the block back up into its input
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rdy_left == 0) begin
          rdy_on = (stall_max == 0) || ($urandom_range(0, 2) != 0);
          rdy_left = rdy_on ? $urandom_range(1, 16) : $urandom_range(1, stall_max);
        end
        rdy_left--;
        m_tready <= rdy_on;
      end
    end
  end

  // Watchdog: count cycles in which no item moves on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("terminal_line_editor_top test failed");
        $finish;
      end
    end
  end

  // Write one register at an idle point and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ERASE:      keymap.erase_char = val;
      REG_KILL:       keymap.kill_char = val;
      REG_WORD_ERASE: keymap.word_erase_char = val;
      REG_END:        keymap.end_char = val;
      default:        ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every key is taken and every echo item is back, then settle
  task automatic wait_idle();
    while (pending_keys.size() != 0 || s_tvalid || echo_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Append random typing: mostly words with spaces, mixed with edits and noise.
  // The end key only follows a printable, so the session never stops by accident.
  task automatic queue_keys(input int count);
    int         base;
    int         pick;
    logic [7:0] b;
    base = pending_keys.size();
    while (pending_keys.size() - base < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 12)) pending_keys.push_back(8'($urandom_range(8'h21, 8'h7E)));
        repeat ($urandom_range(0, 3)) pending_keys.push_back(CH_SPACE);
      end else if (pick < 65) begin
        pending_keys.push_back(keymap.erase_char);
      end else if (pick < 75) begin
        pending_keys.push_back(keymap.word_erase_char);
      end else if (pick < 78) begin
        pending_keys.push_back(keymap.kill_char);
      end else if (pick < 81) begin
        pending_keys.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      end else if (pick < 86) begin
        pending_keys.push_back(8'($urandom_range(8'h20, 8'h7E)));
        pending_keys.push_back(keymap.end_char);
      end else begin
        b = 8'($urandom_range(0, 255));
        while (b == keymap.end_char) b = 8'($urandom_range(0, 255));
        pending_keys.push_back(b);
      end
    end
  endtask

  // Opening keys at reset settings: field extremes, every edit, empty-line cases
  logic [7:0] opening [24] = '{
    CH_SPACE, CH_TILDE, "h", "i", CH_SPACE, "y",
    WORD_ERASE_RESET, WORD_ERASE_RESET, WORD_ERASE_RESET,   // down to an empty line
    ERASE_RESET,                                            // erase on empty line
    "z", END_RESET,                                         // end on a nonempty line
    ERASE_RESET, ERASE_RESET, KILL_RESET,                   // kill on empty line
    "q", KILL_RESET, CH_CR, CH_LF,
    CH_NUL, 8'h7F, 8'h80, 8'hFF, 8'h1F                      // bell bytes
  };

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings, light idling on both sides
    foreach (opening[i]) pending_keys.push_back(opening[i]);
    queue_keys(60);
    wait_idle();

    // All registers at control-byte extremes; heavier idling
    write_reg(REG_ERASE, 8'h7F);
    write_reg(REG_KILL, 8'h00);
    write_reg(REG_WORD_ERASE, 8'hFF);
    write_reg(REG_END, 8'h1C);
    gap_max = 12;
    burst_max = 30;
    stall_max = 8;
    queue_keys(60);
    wait_idle();

    // Printable erase never fires; CR becomes kill, backspace becomes word erase.
    // Hold the receiver off while the sender keeps pushing.
    write_reg(REG_ERASE, "a");
    write_reg(REG_KILL, CH_CR);
    write_reg(REG_WORD_ERASE, 8'h08);
    write_reg(REG_END, 8'hFF);
    gap_max = 2;
    burst_max = 20;
    stall_max = 4;
    queue_keys(60);
    long_hold_ask = 1'b1;
    wait_idle();

    // Random registers, no idling at all
    write_reg(REG_ERASE, 8'($urandom_range(0, 255)));
    write_reg(REG_KILL, 8'($urandom_range(0, 255)));
    write_reg(REG_WORD_ERASE, 8'($urandom_range(0, 255)));
    write_reg(REG_END, 8'($urandom_range(0, 255)));
    gap_max = 0;
    burst_max = 64;
    stall_max = 0;
    queue_keys(70);
    wait_idle();

    // Back to reset values, then end the session on an empty line
    write_reg(REG_ERASE, ERASE_RESET);
    write_reg(REG_KILL, KILL_RESET);
    write_reg(REG_WORD_ERASE, WORD_ERASE_RESET);
    write_reg(REG_END, END_RESET);
    gap_max = 6;
    burst_max = 12;
    stall_max = 10;
    queue_keys(60);
    pending_keys.push_back(CH_CR);
    pending_keys.push_back(END_RESET);
    // Keys after the stop are swallowed
    pending_keys.push_back("a");
    pending_keys.push_back(END_RESET);
    pending_keys.push_back(8'hFF);
    stall_max = 0;
    wait_idle();

    if (fail_count == 0) begin
      $display("terminal_line_editor_top test passed");
    end else begin
      $display("terminal_line_editor_top test failed");
    end
    $finish;
  end

endmodule
